[rtl/frb_pkg.sv]
`timescale 1ns / 1ps

package frb_pkg;

	// Buffer geometry.
	localparam int NUM_SLOTS   = 4;
	localparam int SLOT_BYTES  = 1024;
	localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int OFF_W       = $clog2(SLOT_BYTES);
	localparam int ADDR_W      = SLOT_W + OFF_W;
	localparam int MEM_DEPTH   = NUM_SLOTS * SLOT_BYTES;

	// Widths used for range compares of offsets and slot selects.
	localparam int OFF_XW      = 13;
	localparam int SEL_XW      = 5;

	// Command queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;
	localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_STORE   = 2'd0,
		OP_READ    = 2'd1,
		OP_RELEASE = 2'd2,
		OP_UNUSED  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_STORED   = 2'd0,
		ST_COMPLETE = 2'd1,
		ST_DROPPED  = 2'd2,
		ST_DONE     = 2'd3
	} status_t;

	// Result fields that are settled by the front.
	typedef struct packed {
		status_t     status;
		logic [1:0]  slot;
		logic [15:0] done_id;
		logic [10:0] total_length;
	} result_t;

	// One command for the back: an optional buffer access plus the result.
	typedef struct packed {
		logic              wr_en;
		logic              rd_en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
		result_t           res;
	} entry_t;

endpackage

[rtl/frb_req_if.sv]
`timescale 1ns / 1ps

interface frb_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [15:0] frag_id;
	logic [9:0]  byte_offset;
	logic [7:0]  data_byte;
	logic        final_fragment;
	logic        fragment_end;
	logic [1:0]  slot_select;

	modport source (
		output valid, operation, frag_id, byte_offset, data_byte,
		       final_fragment, fragment_end, slot_select,
		input  ready
	);

	modport sink (
		input  valid, operation, frag_id, byte_offset, data_byte,
		       final_fragment, fragment_end, slot_select,
		output ready
	);
endinterface

[rtl/frb_rsp_if.sv]
`timescale 1ns / 1ps

interface frb_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [1:0]  slot;
	logic [15:0] done_id;
	logic [10:0] total_length;
	logic [7:0]  read_byte;

	modport source (
		output valid, status, slot, done_id, total_length, read_byte,
		input  ready
	);

	modport sink (
		input  valid, status, slot, done_id, total_length, read_byte,
		output ready
	);
endinterface

[rtl/frb_front.sv]
`timescale 1ns / 1ps

module frb_front (
	input  logic              clk,
	input  logic              arst_n,
	frb_req_if.sink           req,
	input  logic              q_full,
	output logic              push,
	output frb_pkg::entry_t   push_entry
);

	logic [frb_pkg::NUM_SLOTS-1:0] valid_q;
	logic [15:0]                   ident_q [frb_pkg::NUM_SLOTS];

	logic [frb_pkg::NUM_SLOTS-1:0] hit;
	logic                          hit_any;
	logic                          free_any;
	logic [frb_pkg::SLOT_W-1:0]    hit_idx;
	logic [frb_pkg::SLOT_W-1:0]    free_idx;
	logic [frb_pkg::SLOT_W-1:0]    use_idx;
	logic [frb_pkg::SLOT_W-1:0]    sel_idx;
	logic                          drop;
	logic                          alloc;
	logic                          sel_ok;
	logic                          off_ok;
	logic [frb_pkg::OFF_XW-1:0]    off_x;
	logic                          is_store;
	logic                          is_release;

	// Accept a word whenever the command queue has room.
	assign req.ready = !q_full;
	assign push      = req.valid && req.ready;

	// Range checks on the offset and on the addressed slot.
	assign off_x   = frb_pkg::OFF_XW'(req.byte_offset);
	assign off_ok  = off_x < frb_pkg::OFF_XW'(frb_pkg::SLOT_BYTES);
	assign sel_ok  = frb_pkg::SEL_XW'(req.slot_select) < frb_pkg::SEL_XW'(frb_pkg::NUM_SLOTS);
	assign sel_idx = frb_pkg::SLOT_W'(req.slot_select);

	// Parallel id compare and lowest-index pick of a hit and a free slot.
	always_comb begin
		hit_any  = 1'b0;
		free_any = 1'b0;
		hit_idx  = '0;
		free_idx = '0;
		for (int i = 0; i < frb_pkg::NUM_SLOTS; i++) begin
			hit[i] = valid_q[i] && (ident_q[i] == req.frag_id);
		end
		for (int i = frb_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
			if (hit[i]) begin
				hit_any = 1'b1;
				hit_idx = frb_pkg::SLOT_W'(i);
			end
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = frb_pkg::SLOT_W'(i);
			end
		end
	end

	assign use_idx = hit_any ? hit_idx : free_idx;
	assign drop    = !hit_any && !free_any;
	assign alloc   = !hit_any && free_any;

	// Classify the word and build the command for the back.
	always_comb begin
		is_store                     = 1'b0;
		is_release                   = 1'b0;
		push_entry.wr_en             = 1'b0;
		push_entry.rd_en             = 1'b0;
		push_entry.addr              = {sel_idx, off_x[frb_pkg::OFF_W-1:0]};
		push_entry.data              = req.data_byte;
		push_entry.res.status        = frb_pkg::ST_DONE;
		push_entry.res.slot          = req.slot_select;
		push_entry.res.done_id       = '0;
		push_entry.res.total_length  = '0;
		unique case (frb_pkg::op_t'(req.operation))
			frb_pkg::OP_STORE: begin
				is_store = 1'b1;
				push_entry.addr = {use_idx, off_x[frb_pkg::OFF_W-1:0]};
				if (drop) begin
					push_entry.res.status = frb_pkg::ST_DROPPED;
					push_entry.res.slot   = '0;
				end else begin
					push_entry.wr_en    = off_ok;
					push_entry.res.slot = 2'(use_idx);
					if (req.final_fragment && req.fragment_end) begin
						push_entry.res.status       = frb_pkg::ST_COMPLETE;
						push_entry.res.done_id      = req.frag_id;
						push_entry.res.total_length = 11'(req.byte_offset) + 11'd1;
					end else begin
						push_entry.res.status = frb_pkg::ST_STORED;
					end
				end
			end
			frb_pkg::OP_READ: begin
				push_entry.rd_en = sel_ok && off_ok;
			end
			frb_pkg::OP_RELEASE: begin
				is_release = 1'b1;
			end
			frb_pkg::OP_UNUSED: begin
				is_release = 1'b0;
			end
			default: begin
				is_release = 1'b0;
			end
		endcase
	end

	// Slot occupancy: claimed by a new id, freed by a release.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (push) begin
			if (is_store && alloc) begin
				valid_q[use_idx] <= 1'b1;
			end
			if (is_release && sel_ok) begin
				valid_q[sel_idx] <= 1'b0;
			end
		end
	end

	// Slot identifiers are recorded on allocation only.
	always_ff @(posedge clk) begin
		if (push && is_store && alloc) begin
			ident_q[use_idx] <= req.frag_id;
		end
	end

	// A store that is not dropped leaves its slot occupied.
	a_store_claims: assert property (@(posedge clk) disable iff (!arst_n)
		(push && is_store && !drop) |=> valid_q[$past(use_idx)])
		else $error("stored slot not valid after store");

	// A drop happens only with every slot occupied.
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(push && is_store && drop) |-> (&valid_q))
		else $error("byte dropped while a slot was free");

	// A claimed slot records the id of the word that claimed it.
	a_ident_rec: assert property (@(posedge clk) disable iff (!arst_n)
		(push && is_store && alloc) |=> (ident_q[$past(use_idx)] == $past(req.frag_id)))
		else $error("claimed slot lost its identifier");

endmodule

[rtl/frb_queue.sv]
`timescale 1ns / 1ps

module frb_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  frb_pkg::entry_t push_entry,
	output logic            full,
	input  logic            pop,
	output logic            q_valid,
	output frb_pkg::entry_t q_entry
);

	frb_pkg::entry_t              mem_q [frb_pkg::QUEUE_DEPTH];
	logic [frb_pkg::PTR_W-1:0]    wr_ptr_q;
	logic [frb_pkg::PTR_W-1:0]    rd_ptr_q;
	logic [frb_pkg::CNT_W-1:0]    count_q;

	assign full    = count_q == frb_pkg::CNT_W'(frb_pkg::QUEUE_DEPTH);
	assign q_valid = count_q != '0;
	assign q_entry = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == frb_pkg::PTR_W'(frb_pkg::QUEUE_DEPTH - 1)) ?
				            '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == frb_pkg::PTR_W'(frb_pkg::QUEUE_DEPTH - 1)) ?
				            '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!q_valid |-> !pop)
		else $error("pop from an empty queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= frb_pkg::CNT_W'(frb_pkg::QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule

[rtl/frb_back.sv]
`timescale 1ns / 1ps

module frb_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  frb_pkg::entry_t q_entry,
	output logic            pop,
	frb_rsp_if.source       rsp
);

	logic [7:0]       buf_q [frb_pkg::MEM_DEPTH];
	logic [7:0]       rdata_q;
	logic             rd_en_q;
	logic             out_v_q;
	frb_pkg::result_t res_q;

	// Take the next command when the output register is free or being emptied.
	assign pop = q_valid && (!out_v_q || rsp.ready);

	// Reassembly buffer: at most one write and one read per command.
	always_ff @(posedge clk) begin
		if (pop) begin
			if (q_entry.wr_en) begin
				buf_q[q_entry.addr] <= q_entry.data;
			end
			rdata_q <= buf_q[q_entry.addr];
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			res_q   <= q_entry.res;
			rd_en_q <= q_entry.rd_en;
		end
	end

	// Output word valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (pop) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	assign rsp.valid        = out_v_q;
	assign rsp.status       = res_q.status;
	assign rsp.slot         = res_q.slot;
	assign rsp.done_id      = res_q.done_id;
	assign rsp.total_length = res_q.total_length;
	assign rsp.read_byte    = rd_en_q ? rdata_q : 8'd0;

	a_len_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && res_q.status == frb_pkg::ST_COMPLETE) |-> (res_q.total_length != '0))
		else $error("completion with zero length");

	a_id_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && res_q.status != frb_pkg::ST_COMPLETE) |->
		(res_q.done_id == '0 && res_q.total_length == '0))
		else $error("completion fields set on a non-completion word");

	a_read_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && rd_en_q) |-> (res_q.status == frb_pkg::ST_DONE))
		else $error("read data on a word that is not a read");

endmodule

[rtl/fragment_reassembly_buffer.sv]
`timescale 1ns / 1ps

// A word accepted by the front is written into the command queue; the back moves its
// result word into an output register, which holds it until the result side takes it.
// Throughput: one word per cycle while the result side is ready; a full queue stalls requests.
// A two-entry command queue parts the slot lookup from the buffer and output.
// Reset frees all slots and empties the queue and the output register; the byte
// buffer is not cleared, and reads of bytes never written are undefined.

module fragment_reassembly_buffer (
	input  logic     clk,
	input  logic     arst_n,
	frb_req_if.sink  req,
	frb_rsp_if.source rsp
);

	logic            push;
	logic            pop;
	logic            q_full;
	logic            q_valid;
	frb_pkg::entry_t push_entry;
	frb_pkg::entry_t q_entry;

	frb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	frb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.q_valid    (q_valid),
		.q_entry    (q_entry)
	);

	frb_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_entry (q_entry),
		.pop     (pop),
		.rsp     (rsp)
	);

endmodule

[sim/frb_reassembly_checker.sv]
`timescale 1ns / 1ps

// Watches both channels of the reassembly buffer, predicts the result word of every
// accepted request word and compares it, field by field, with the words that come out.
module frb_reassembly_checker (
	input  logic clk,
	input  logic arst_n,
	frb_req_if   req,
	frb_rsp_if   rsp,
	output int   errors,
	output int   outstanding,
	output int   completions,
	output int   drops,
	output int   reads
);

	localparam int REPORT_LIMIT = 30;

	typedef struct packed {
		frb_pkg::status_t status;
		logic [1:0]       slot;
		logic [15:0]      done_id;
		logic [10:0]      total_length;
		logic [7:0]       read_byte;
	} reply_t;

	// Shadow of the slot table and of the byte storage.
	bit          slot_busy [frb_pkg::NUM_SLOTS];
	logic [15:0] slot_tag [frb_pkg::NUM_SLOTS];
	logic [7:0]  byte_store [frb_pkg::NUM_SLOTS][frb_pkg::SLOT_BYTES];
	reply_t      reply_q [$];

	// Applies one request word to the shadow state and returns the result it must give.
	function automatic reply_t reassemble(frb_pkg::op_t op, logic [15:0] id, logic [9:0] off,
		logic [7:0] data, logic fin, logic fend, logic [1:0] sel);
		reply_t r;
		int hit;
		r = '0;
		hit = -1;
		case (op)
		frb_pkg::OP_STORE: begin
			// An open datagram with the same id wins; otherwise the lowest free slot.
			for (int i = 0; i < frb_pkg::NUM_SLOTS; i++)
				if (hit < 0 && slot_busy[i] && slot_tag[i] == id)
					hit = i;
			if (hit < 0) begin
				for (int i = 0; i < frb_pkg::NUM_SLOTS; i++)
					if (hit < 0 && !slot_busy[i])
						hit = i;
				if (hit >= 0) begin
					slot_busy[hit] = 1'b1;
					slot_tag[hit] = id;
				end
			end
			if (hit < 0) begin
				r.status = frb_pkg::ST_DROPPED;
			end else begin
				if (off < frb_pkg::SLOT_BYTES)
					byte_store[hit][off] = data;
				r.slot = hit[1:0];
				if (fin && fend) begin
					r.status = frb_pkg::ST_COMPLETE;
					r.done_id = id;
					r.total_length = 11'(off) + 11'd1;
				end else begin
					r.status = frb_pkg::ST_STORED;
				end
			end
		end
		frb_pkg::OP_READ: begin
			r.status = frb_pkg::ST_DONE;
			r.slot = sel;
			if (sel < frb_pkg::NUM_SLOTS && off < frb_pkg::SLOT_BYTES)
				r.read_byte = byte_store[sel][off];
		end
		default: begin
			// Release frees the slot; the unused code only answers.
			if (op == frb_pkg::OP_RELEASE && sel < frb_pkg::NUM_SLOTS)
				slot_busy[sel] = 1'b0;
			r.status = frb_pkg::ST_DONE;
			r.slot = sel;
		end
		endcase
		return r;
	endfunction

	task automatic check_field(string what, int unsigned want, int unsigned got);
		if (want != got) begin
			errors++;
			if (errors <= REPORT_LIMIT)
				$display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
		end
	endtask

	// Requests are predicted first, then any result word on this edge is compared.
	always @(posedge clk) begin
		reply_t want;
		if (arst_n) begin
			if (req.valid && req.ready) begin
				if (req.operation == frb_pkg::OP_READ)
					reads++;
				reply_q.push_back(reassemble(frb_pkg::op_t'(req.operation), req.frag_id,
					req.byte_offset, req.data_byte, req.final_fragment,
					req.fragment_end, req.slot_select));
			end
			if (rsp.valid && rsp.ready) begin
				if (reply_q.size() == 0) begin
					errors++;
					if (errors <= REPORT_LIMIT)
						$display("%0t: result word with none expected, status %0d slot %0d",
							$time, rsp.status, rsp.slot);
				end else begin
					want = reply_q.pop_front();
					if (want.status == frb_pkg::ST_COMPLETE)
						completions++;
					if (want.status == frb_pkg::ST_DROPPED)
						drops++;
					check_field("status", 32'(want.status), 32'(rsp.status));
					check_field("slot", 32'(want.slot), 32'(rsp.slot));
					check_field("done_id", 32'(want.done_id), 32'(rsp.done_id));
					check_field("total_length", 32'(want.total_length),
						32'(rsp.total_length));
					check_field("read_byte", 32'(want.read_byte), 32'(rsp.read_byte));
				end
			end
			outstanding = reply_q.size();
		end
	end

endmodule

[sim/fragment_reassembly_buffer_test.sv]
`timescale 1ns / 1ps

module fragment_reassembly_buffer_test;

	localparam int WORD_TARGET = 1550;
	localparam int CALM_FROM   = 1350;

	logic clk;
	logic arst_n;
	int   errors;
	int   outstanding;
	int   completions;
	int   drops;
	int   reads;
	int   sent;
	int   landed;

	// Which slot holds which datagram, and which bytes have ever been written, so that
	// reads only go to bytes that hold data.
	bit         tb_busy [frb_pkg::NUM_SLOTS];
	bit [15:0]  tb_tag [frb_pkg::NUM_SLOTS];
	bit         written [frb_pkg::NUM_SLOTS][frb_pkg::SLOT_BYTES];
	int         written_list [frb_pkg::NUM_SLOTS][$];

	// No idling in every fourth stretch of 150 words and none near the end.
	wire calm = (sent >= CALM_FROM) || ((sent / 150) % 4 == 3);

	frb_req_if req ();
	frb_rsp_if rsp ();

	fragment_reassembly_buffer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	frb_reassembly_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.errors      (errors),
		.outstanding (outstanding),
		.completions (completions),
		.drops       (drops),
		.reads       (reads)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("fragment_reassembly_buffer verification failed");
		$finish;
	end

	// Result side: random stall bursts outside the calm stretches.
	int stall_left;
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else if (stall_left > 0) begin
			rsp.ready <= 1'b0;
			stall_left--;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			rsp.ready <= 1'b0;
			stall_left = $urandom_range(1, 9) - 1;
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	// Drives one request word and waits until it is taken.
	task automatic send_word(frb_pkg::op_t op, logic [15:0] id, logic [9:0] off,
		logic [7:0] data, logic fin, logic fend, logic [1:0] sel);
		int s;
		if (!calm && $urandom_range(0, 4) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		// Track where a store lands so that later reads hit written bytes.
		s = -1;
		if (op == frb_pkg::OP_STORE) begin
			for (int i = 0; i < frb_pkg::NUM_SLOTS; i++)
				if (s < 0 && tb_busy[i] && tb_tag[i] == id)
					s = i;
			for (int i = 0; i < frb_pkg::NUM_SLOTS; i++)
				if (s < 0 && !tb_busy[i]) begin
					s = i;
					tb_busy[i] = 1'b1;
					tb_tag[i] = id;
				end
			if (s >= 0 && !written[s][off]) begin
				written[s][off] = 1'b1;
				written_list[s].push_back(int'(off));
			end
		end else if (op == frb_pkg::OP_RELEASE && sel < frb_pkg::NUM_SLOTS) begin
			tb_busy[sel] = 1'b0;
		end
		landed = s;
		req.valid          <= 1'b1;
		req.operation      <= op;
		req.frag_id        <= id;
		req.byte_offset    <= off;
		req.data_byte      <= data;
		req.final_fragment <= fin;
		req.fragment_end   <= fend;
		req.slot_select    <= sel;
		sent++;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
	endtask

	// Reads one byte of a slot that has been written before, if there is one.
	task automatic read_back(int s);
		int n;
		n = written_list[s].size();
		if (n != 0)
			send_word(frb_pkg::OP_READ, 16'($urandom_range(0, 65535)),
				10'(written_list[s][$urandom_range(0, n - 1)]),
				8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), s[1:0]);
	endtask

	// One datagram as one to four fragments at random offsets; when closes is set, every
	// byte of the last fragment carries the final-fragment flag; the last byte of each fragment carries fragment_end.
	task automatic send_datagram(logic [15:0] id, bit closes);
		int frags;
		int len;
		logic [9:0] base;
		frags = $urandom_range(1, 4);
		for (int f = 0; f < frags; f++) begin
			len = $urandom_range(1, 6);
			base = 10'($urandom_range(0, frb_pkg::SLOT_BYTES - 1));
			for (int b = 0; b < len; b++)
				send_word(frb_pkg::OP_STORE, id, base + 10'(b), 8'($urandom_range(0, 255)),
					closes && (f == frags - 1), b == len - 1, 2'($urandom_range(0, 3)));
		end
	endtask

	// Stray words: reads, releases, the unused code and stores with random flags.
	task automatic send_noise();
		case ($urandom_range(0, 4))
		0: read_back($urandom_range(0, frb_pkg::NUM_SLOTS - 1));
		1: send_word(frb_pkg::OP_RELEASE, 16'($urandom_range(0, 65535)),
			10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
		2: send_word(frb_pkg::OP_UNUSED, 16'($urandom_range(0, 65535)),
			10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
		default: send_word(frb_pkg::OP_STORE, 16'($urandom_range(0, 65535)),
			10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
		endcase
	endtask

	initial begin
		logic [15:0] id;
		bit closes;
		int s;
		arst_n             = 1'b0;
		req.valid          = 1'b0;
		req.operation      = frb_pkg::OP_STORE;
		req.frag_id        = '0;
		req.byte_offset    = '0;
		req.data_byte      = '0;
		req.final_fragment = 1'b0;
		req.fragment_end   = 1'b0;
		req.slot_select    = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, slot claim and match, completion, drop on a full
		// table, reads of live and freed slots, double release and the unused code.
		send_word(frb_pkg::OP_STORE, 16'h0000, 10'd0, 8'h00, 1'b0, 1'b0, 2'd0);
		send_word(frb_pkg::OP_STORE, 16'h0000, 10'd1023, 8'hFF, 1'b1, 1'b0, 2'd3);
		send_word(frb_pkg::OP_STORE, 16'h0000, 10'd1, 8'h5A, 1'b1, 1'b1, 2'd0);
		send_word(frb_pkg::OP_STORE, 16'hFFFF, 10'd1023, 8'hA5, 1'b1, 1'b1, 2'd0);
		send_word(frb_pkg::OP_STORE, 16'h1234, 10'd512, 8'h80, 1'b0, 1'b1, 2'd1);
		send_word(frb_pkg::OP_STORE, 16'h8001, 10'd7, 8'h01, 1'b0, 1'b0, 2'd2);
		send_word(frb_pkg::OP_STORE, 16'h4242, 10'd3, 8'h09, 1'b1, 1'b1, 2'd0);
		send_word(frb_pkg::OP_STORE, 16'h0000, 10'd2, 8'h33, 1'b0, 1'b0, 2'd0);
		send_word(frb_pkg::OP_READ, 16'hFFFF, 10'd0, 8'hFF, 1'b1, 1'b1, 2'd0);
		send_word(frb_pkg::OP_READ, 16'h0000, 10'd1023, 8'h00, 1'b0, 1'b0, 2'd0);
		send_word(frb_pkg::OP_READ, 16'h0000, 10'd1023, 8'h00, 1'b0, 1'b0, 2'd1);
		send_word(frb_pkg::OP_READ, 16'h0000, 10'd7, 8'h00, 1'b0, 1'b0, 2'd3);
		send_word(frb_pkg::OP_READ, 16'h0000, 10'd512, 8'h00, 1'b0, 1'b0, 2'd2);
		send_word(frb_pkg::OP_UNUSED, 16'hBEEF, 10'd1023, 8'hFF, 1'b1, 1'b1, 2'd2);
		send_word(frb_pkg::OP_RELEASE, 16'h0000, 10'd0, 8'h00, 1'b0, 1'b0, 2'd0);
		send_word(frb_pkg::OP_READ, 16'h0000, 10'd1, 8'h00, 1'b0, 1'b0, 2'd0);
		send_word(frb_pkg::OP_RELEASE, 16'hFFFF, 10'd1023, 8'hFF, 1'b1, 1'b1, 2'd0);
		send_word(frb_pkg::OP_STORE, 16'h4242, 10'd0, 8'h77, 1'b1, 1'b1, 2'd3);
		send_word(frb_pkg::OP_RELEASE, 16'h0000, 10'd0, 8'h00, 1'b0, 1'b0, 2'd1);
		send_word(frb_pkg::OP_RELEASE, 16'h0000, 10'd0, 8'h00, 1'b0, 1'b0, 2'd2);
		send_word(frb_pkg::OP_RELEASE, 16'h0000, 10'd0, 8'h00, 1'b0, 1'b0, 2'd3);
		send_word(frb_pkg::OP_RELEASE, 16'h0000, 10'd0, 8'h00, 1'b0, 1'b0, 2'd0);

		// Random: mostly whole datagrams, read back and released, with abandoned
		// datagrams and stray words mixed in so that the table fills and drops occur.
		while (sent < WORD_TARGET) begin
			if ($urandom_range(0, 9) < 7) begin
				s = $urandom_range(0, frb_pkg::NUM_SLOTS - 1);
				if ($urandom_range(0, 9) == 0 && tb_busy[s])
					id = tb_tag[s];
				else
					id = 16'($urandom_range(0, 65535));
				closes = $urandom_range(0, 6) != 0;
				send_datagram(id, closes);
				if (closes && landed >= 0 && $urandom_range(0, 9) < 7) begin
					s = landed;
					repeat ($urandom_range(1, 4))
						read_back(s);
					send_word(frb_pkg::OP_RELEASE, 16'($urandom_range(0, 65535)),
						10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), s[1:0]);
				end
			end else begin
				send_noise();
			end
		end
		req.valid <= 1'b0;

		// Drain the remaining results, then wait for anything stray.
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		$display("Sent %0d request words: %0d datagrams completed, %0d bytes dropped,",
			sent, completions, drops);
		$display("%0d byte reads, %0d field mismatches.", reads, errors);
		if (errors == 0)
			$display("fragment_reassembly_buffer verification clean");
		else
			$display("fragment_reassembly_buffer verification failed");
		$finish;
	end

endmodule

[fragment_reassembly_buffer.f]
rtl/frb_pkg.sv
rtl/frb_req_if.sv
rtl/frb_rsp_if.sv
rtl/frb_front.sv
rtl/frb_queue.sv
rtl/frb_back.sv
rtl/fragment_reassembly_buffer.sv
sim/frb_reassembly_checker.sv
sim/fragment_reassembly_buffer_test.sv
